// File: hw/rtl/xlgp_pkg.sv
// Shared types and constants for the Xing/LAME gapless header parser.
package xlgp_pkg;

  localparam int unsigned ValueW = 12;
  localparam int unsigned DelayW = 13;
  localparam int unsigned OutDataW = 32;

  // Default decoder latency in samples.
  localparam logic [ValueW-1:0] DecoderDelayReset = 12'd529;

  // Parse status after the current byte has been taken.
  typedef struct packed {
    logic              xing_found;
    logic              lame_found;
    logic [ValueW-1:0] lame_delay;
    logic [ValueW-1:0] lame_padding;
  } parse_status_t;

endpackage

// File: hw/rtl/xlgp_parse.sv
// Byte-serial phase tracker that walks the Xing/Info header into the LAME block.
module xlgp_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output xlgp_pkg::parse_status_t status_next
);

  localparam logic [3:0] PH_MAGIC      = 4'd0;
  localparam logic [3:0] PH_FLAGS      = 4'd1;
  localparam logic [3:0] PH_FRAMES     = 4'd2;
  localparam logic [3:0] PH_BYTES      = 4'd3;
  localparam logic [3:0] PH_TOC        = 4'd4;
  localparam logic [3:0] PH_SCALE      = 4'd5;
  localparam logic [3:0] PH_LAME_MAGIC = 4'd6;
  localparam logic [3:0] PH_LAME_SKIP  = 4'd7;
  localparam logic [3:0] PH_LAME_BLOCK = 4'd8;
  localparam logic [3:0] PH_DONE       = 4'd9;

  localparam logic [31:0] TAG_XING = 32'h5869_6E67;
  localparam logic [31:0] TAG_INFO = 32'h496E_666F;
  localparam logic [31:0] TAG_LAME = 32'h4C41_4D45;

  function automatic logic [6:0] phase_len(input logic [3:0] ph);
    logic [6:0] len;
    case (ph)
      PH_TOC:        len = 7'd100;
      PH_LAME_SKIP:  len = 7'd5;
      PH_LAME_BLOCK: len = 7'd15;
      default:       len = 7'd4;
    endcase
    return len;
  endfunction

  // First optional field after ph whose flag is set, else the LAME magic.
  function automatic logic [3:0] next_optional(input logic [3:0] ph, input logic [3:0] flags);
    logic [3:0] nxt;
    logic [3:0] cand;
    nxt = PH_LAME_MAGIC;
    for (int i = 3; i >= 0; i--) begin
      cand = PH_FRAMES + 4'(i);
      if (flags[i] && (cand > ph)) begin
        nxt = cand;
      end
    end
    return nxt;
  endfunction

  logic [3:0]  phase;
  logic [6:0]  offset;
  logic [31:0] shift;
  logic [3:0]  flags;
  logic [xlgp_pkg::ValueW-1:0] lame_delay;
  logic [xlgp_pkg::ValueW-1:0] lame_padding;
  logic        xing_found;
  logic        lame_found;

  logic [3:0]  phase_next;
  logic [6:0]  offset_next;
  logic [31:0] shift_next;
  logic [3:0]  flags_next;
  logic [6:0]  offset_inc;

  always_comb begin
    phase_next  = phase;
    offset_next = offset;
    shift_next  = shift;
    flags_next  = flags;
    status_next = '{xing_found: xing_found, lame_found: lame_found,
                    lame_delay: lame_delay, lame_padding: lame_padding};
    offset_inc  = offset + 7'd1;
    if (phase < PH_DONE) begin
      shift_next  = {shift[23:0], data_byte};
      offset_next = offset_inc;
      if (offset_inc >= phase_len(phase)) begin
        offset_next = '0;
        case (phase)
          PH_MAGIC: begin
            if (shift_next == TAG_XING || shift_next == TAG_INFO) begin
              status_next.xing_found = 1'b1;
              phase_next = PH_FLAGS;
            end else begin
              phase_next = PH_DONE;
            end
          end
          PH_FLAGS: begin
            flags_next = shift_next[3:0];
            phase_next = next_optional(PH_FLAGS, shift_next[3:0]);
          end
          PH_FRAMES, PH_BYTES, PH_TOC, PH_SCALE: begin
            phase_next = next_optional(phase, flags);
          end
          PH_LAME_MAGIC: begin
            phase_next = (shift_next == TAG_LAME) ? PH_LAME_SKIP : PH_DONE;
          end
          PH_LAME_SKIP: begin
            phase_next = PH_LAME_BLOCK;
          end
          PH_LAME_BLOCK: begin
            status_next.lame_delay   = shift_next[23:12];
            status_next.lame_padding = shift_next[11:0];
            status_next.lame_found   = 1'b1;
            phase_next = PH_DONE;
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase        <= PH_MAGIC;
      offset       <= '0;
      shift        <= '0;
      flags        <= '0;
      lame_delay   <= '0;
      lame_padding <= '0;
      xing_found   <= 1'b0;
      lame_found   <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      offset       <= offset_next;
      shift        <= shift_next;
      flags        <= flags_next;
      lame_delay   <= status_next.lame_delay;
      lame_padding <= status_next.lame_padding;
      xing_found   <= status_next.xing_found;
      lame_found   <= status_next.lame_found;
    end
  end

endmodule

// File: hw/rtl/xing_lame_gapless_header_parser.sv
// Top level: Xing/Info + LAME gapless header parser with output register.
//
// Usage:
//   s_* channel takes the ancillary bytes of the first MP3 frame, one byte per
//   request; s_tlast marks the final byte. Only that final byte produces a
//   result on the m_* channel: found flags, total delay and trailing padding.
//   cfg_* writes the 12-bit decoder delay (reset 529); it may be written only
//   while no frame is in progress and no result is pending.
// Timing:
//   One byte per cycle sustained unless a pending result stalls the input. The
//   result of the last byte shows on m_* in the cycle after it is accepted
//   (one output register). The byte-phase tracker and the final add/subtract
//   sit between the input handshake and that register.
// Reset (rst, synchronous): parser returns to the magic phase, output empty,
//   decoder delay back to 529. After each final byte the parser restarts.
// Stall: while a result waits and m_tready is low, s_tready drops; a result
//   being taken in the same cycle frees the register for the next request.
module xing_lame_gapless_header_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] data_byte
  input  logic                            s_tlast,  // last_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] xing_found, [1] lame_found, [14:2] total_delay,
  // [26:15] trailing_padding, [31:27] zero
  output logic [xlgp_pkg::OutDataW-1:0]   m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xlgp_pkg::ValueW-1:0]     cfg_data
);

  logic [xlgp_pkg::ValueW-1:0] decoder_delay;
  xlgp_pkg::parse_status_t     status_next;
  logic                        take;
  logic [xlgp_pkg::DelayW-1:0] delay_sum;
  logic [xlgp_pkg::ValueW-1:0] pad_diff;
  logic [xlgp_pkg::OutDataW-1:0] result;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_delay <= xlgp_pkg::DecoderDelayReset;
    end else if (cfg_valid && cfg_ready) begin
      decoder_delay <= cfg_data;
    end
  end

  xlgp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (s_tdata),
    .last_byte   (s_tlast),
    .status_next (status_next)
  );

  always_comb begin
    delay_sum = {1'b0, decoder_delay};
    pad_diff  = '0;
    if (status_next.lame_found) begin
      delay_sum = {1'b0, decoder_delay} + {1'b0, status_next.lame_delay};
      if (status_next.lame_padding > decoder_delay) begin
        pad_diff = status_next.lame_padding - decoder_delay;
      end
    end
    result = {5'd0, pad_diff, delay_sum, status_next.lame_found, status_next.xing_found};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_tlast) begin
      m_tdata <= result;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("final byte did not produce a result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_no_lame_no_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[26:15] == '0)
    else $error("padding reported without LAME block");

  a_lame_needs_xing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("LAME found without Xing/Info magic");
`endif

endmodule

// File: tb/sv/tb_xing_lame_gapless_header_parser.sv
// Testbench for the Xing/LAME gapless header parser: byte streams in, predicted results checked.
module tb_xing_lame_gapless_header_parser;

  localparam int ValueW = xlgp_pkg::ValueW;
  localparam int DelayW = xlgp_pkg::DelayW;
  localparam int OutDataW = xlgp_pkg::OutDataW;

  localparam logic [31:0] TAG_XING = 32'h5869_6E67;
  localparam logic [31:0] TAG_INFO = 32'h496E_666F;
  localparam logic [31:0] TAG_LAME = 32'h4C41_4D45;
  localparam int SettleCycles = 4;
  localparam int CycleLimit = 400000;
  localparam int PhaseBytes = 280;
  localparam int MaxReports = 10;

  // header segments, in stream order
  typedef enum logic [3:0] {
    SEG_TAG, SEG_FLAGS, SEG_FRAMES, SEG_BYTES, SEG_TOC, SEG_QUALITY,
    SEG_LAME_TAG, SEG_LAME_SKIP, SEG_LAME_INFO, SEG_STOPPED
  } seg_e;

  typedef struct packed {
    logic [ValueW-1:0] padding;
    logic [DelayW-1:0] delay;
    logic              lame;
    logic              xing;
  } gapless_info_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] data_byte
  logic s_tlast = 1'b0;         // last_byte
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [0] xing_found, [1] lame_found, [14:2] total_delay, [26:15] trailing_padding
  logic [OutDataW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ValueW-1:0] cfg_data = '0;

  xing_lame_gapless_header_parser DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // parser state mirror
  seg_e seg = SEG_TAG;
  logic [7:0] seg_count = '0;
  logic [31:0] tag_window = '0;
  logic [3:0] opt_flags = '0;
  logic [ValueW-1:0] enc_delay_q = '0;
  logic [ValueW-1:0] enc_pad_q = '0;
  logic xing_ok = 1'b0;
  logic lame_ok = 1'b0;
  logic [ValueW-1:0] dec_delay = xlgp_pkg::DecoderDelayReset;

  gapless_info_t expected_info[$];
  logic [7:0] frame_bytes[$];
  int lame_at;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req_len = 0;
  int hold_req_id = 0;
  int hold_seen_id = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int byte_count = 0;
  int frame_count = 0;
  int checked_count = 0;
  int lame_count = 0;
  int setting_count = 0;
  int mismatches = 0;

  initial forever #5 clk = ~clk;

  function automatic int seg_len(input seg_e s);
    case (s)
      SEG_TOC:       return 100;
      SEG_LAME_SKIP: return 5;
      SEG_LAME_INFO: return 15;
      default:       return 4;
    endcase
  endfunction

  // next optional field announced by the flag nibble, else the LAME tag
  function automatic seg_e next_field(input seg_e from);
    for (int q = int'(from) + 1; q <= int'(SEG_QUALITY); q++)
      if (opt_flags[q - int'(SEG_FRAMES)]) return seg_e'(q);
    return SEG_LAME_TAG;
  endfunction

  function automatic void close_segment();
    case (seg)
      SEG_TAG: begin
        if (tag_window == TAG_XING || tag_window == TAG_INFO) begin
          xing_ok = 1'b1;
          seg = SEG_FLAGS;
        end else begin
          seg = SEG_STOPPED;
        end
      end
      SEG_FLAGS: begin
        opt_flags = tag_window[3:0];
        seg = next_field(SEG_FLAGS);
      end
      SEG_FRAMES, SEG_BYTES, SEG_TOC, SEG_QUALITY: seg = next_field(seg);
      SEG_LAME_TAG: seg = (tag_window == TAG_LAME) ? SEG_LAME_SKIP : SEG_STOPPED;
      SEG_LAME_SKIP: seg = SEG_LAME_INFO;
      SEG_LAME_INFO: begin
        enc_delay_q = tag_window[23:12];
        enc_pad_q = tag_window[11:0];
        lame_ok = 1'b1;
        seg = SEG_STOPPED;
      end
      default: seg = SEG_STOPPED;
    endcase
  endfunction

  // one accepted byte; the final byte of a frame queues the expected header info
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    gapless_info_t info;
    if (seg < SEG_STOPPED) begin
      tag_window = {tag_window[23:0], b};
      seg_count = seg_count + 8'd1;
      if (int'(seg_count) >= seg_len(seg)) begin
        seg_count = '0;
        close_segment();
      end
    end
    if (last) begin
      info.xing = xing_ok;
      info.lame = lame_ok;
      info.delay = {1'b0, dec_delay};
      info.padding = '0;
      if (lame_ok) begin
        info.delay = {1'b0, dec_delay} + {1'b0, enc_delay_q};
        info.padding = (enc_pad_q > dec_delay) ? enc_pad_q - dec_delay : '0;
      end
      expected_info.push_back(info);
      seg = SEG_TAG;
      seg_count = '0;
      tag_window = '0;
      opt_flags = '0;
      enc_delay_q = '0;
      enc_pad_q = '0;
      xing_ok = 1'b0;
      lame_ok = 1'b0;
    end
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req_id != hold_seen_id) begin
      hold_seen_id = hold_req_id;
      hold_left = hold_req_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    gapless_info_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_info.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: tdata=%h", m_tdata);
      end else begin
        want = expected_info.pop_front();
        checked_count++;
        if (want.lame) lame_count++;
        if (m_tdata[0] !== want.xing || m_tdata[1] !== want.lame ||
            m_tdata[14:2] !== want.delay || m_tdata[26:15] !== want.padding ||
            m_tdata[31:27] !== 5'd0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"mismatch: expected xing=%0d lame=%0d delay=%0d pad=%0d, ",
                      "got xing=%0d lame=%0d delay=%0d pad=%0d (tdata=%h)"},
                     want.xing, want.lame, want.delay, want.padding,
                     m_tdata[0], m_tdata[1], m_tdata[14:2], m_tdata[26:15], m_tdata);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_xing_lame_gapless_header_parser: FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    absorb_byte(b, last);
    byte_count++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_count++;
  endtask

  // park the sender and wait until every queued result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_info.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_decoder_delay(input logic [ValueW-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    dec_delay = v;
    setting_count++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_random(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void build_header(input logic [31:0] flags, input bit info_tag,
                                       input logic [ValueW-1:0] enc_delay,
                                       input logic [ValueW-1:0] enc_pad, input int tail);
    frame_bytes.delete();
    push_word(info_tag ? TAG_INFO : TAG_XING);
    push_word(flags);
    if (flags[0]) push_random(4);
    if (flags[1]) push_random(4);
    if (flags[2]) push_random(100);
    if (flags[3]) push_random(4);
    lame_at = frame_bytes.size();
    push_word(TAG_LAME);
    push_random(5 + 12);
    frame_bytes.push_back(enc_delay[11:4]);
    frame_bytes.push_back({enc_delay[3:0], enc_pad[11:8]});
    frame_bytes.push_back(enc_pad[7:0]);
    push_random(tail);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ValueW'($urandom);
    endcase
  endfunction

  task automatic test_short_frames();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // tag completed by the last byte itself
    frame_bytes.delete();
    push_word(TAG_XING);
    send_frame();
    // upper flag bits only, stream ends on the flag word
    frame_bytes.delete();
    push_word(TAG_INFO);
    push_word(32'hFFFF_FFF0);
    send_frame();
    frame_bytes.delete();
    push_word(TAG_XING ^ 32'h1);
    frame_bytes.push_back(8'h12);
    send_frame();
    drain_results();
  endtask

  task automatic test_full_headers();
    set_decoder_delay('0);
    build_header(32'h0, 1'b0, '1, '1, 0);
    send_frame();
    build_header(32'h0000_000F, 1'b1, '0, '0, 3);
    send_frame();
    set_decoder_delay('1);
    build_header(32'hFFFF_FFF5, 1'b0, '1, '1, 2);
    send_frame();
    build_header(32'h0000_0002, 1'b1, 12'h123, 12'h0FE, 0);
    send_frame();
    set_decoder_delay(12'd529);
    build_header(32'h8000_0008, 1'b1, 12'h240, 12'hABC, 0);
    send_frame();
    // one byte short of the LAME block
    build_header(32'h0, 1'b0, 12'h555, 12'hAAA, 0);
    void'(frame_bytes.pop_back());
    send_frame();
    build_header(32'h0000_0001, 1'b0, 12'h555, 12'hAAA, 4);
    frame_bytes[lame_at] = frame_bytes[lame_at] ^ 8'h20;
    send_frame();
    drain_results();
  endtask

  // long receiver hold-off while short frames keep coming
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req_len = 200;
    hold_req_id++;
    repeat (40) send_byte(8'($urandom), 1'b1);
    build_header(32'h0, 1'b1, pick_value(), pick_value(), 1);
    send_frame();
    drain_results();
  endtask

  task automatic send_random_frame();
    int pick;
    int cut;
    int pos;
    logic [31:0] flags;
    pick = $urandom_range(99);
    flags = $urandom;
    if ($urandom_range(99) >= 15) flags[2] = 1'b0;
    if (pick < 15) begin
      frame_bytes.delete();
      push_random($urandom_range(1, 8));
    end else begin
      build_header(flags, 1'($urandom_range(1)), pick_value(), pick_value(),
                   $urandom_range(0, 6));
      if (pick < 30) begin
        cut = $urandom_range(1, frame_bytes.size());
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (pick < 40) begin
        pos = $urandom_range(1) ? $urandom_range(3) : lame_at + $urandom_range(3);
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    send_frame();
  endtask

  task automatic test_random_frames();
    int phase_end;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  set_decoder_delay(pick_value()); end
        1: begin idle_pct = 53; stall_pct = 0;  set_decoder_delay('1); end
        2: begin idle_pct = 0;  stall_pct = 53; set_decoder_delay('0); end
        default: begin idle_pct = 19; stall_pct = 19; set_decoder_delay(ValueW'($urandom)); end
      endcase
      phase_end = byte_count + PhaseBytes;
      while (byte_count < phase_end) begin
        send_random_frame();
        if ($urandom_range(15) == 0) drain_results();
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_frames();
    test_full_headers();
    test_backpressure();
    test_random_frames();
    drain_results();
    $display("covered %0d bytes in %0d frames, %0d results checked (%0d with LAME values)",
             byte_count, frame_count, checked_count, lame_count);
    $display("decoder delay written %0d times, extremes included; mismatches: %0d",
             setting_count, mismatches);
    if (mismatches == 0 && expected_info.size() == 0) begin
      $display("tb_xing_lame_gapless_header_parser: PASS");
    end else begin
      $display("tb_xing_lame_gapless_header_parser: FAIL");
    end
    $finish;
  end

endmodule
